// ===== sv/csrv_pkg.sv =====
`default_nettype none

package csrv_pkg;

    // field and datapath widths
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 17;
    localparam int VAR_W   = 48;
    localparam int SUM_W   = 64;
    localparam int STEP_W  = 7;

    // op queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_SD_ZERO = 2'd1;
    localparam t_status ST_SAT     = 2'd2;

    // configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CLIP_MAX   = 1'b0;
    localparam t_cfg_idx CFG_ROW_LENGTH = 1'b1;

    // divider step counts: Q16.16 standardize (48-bit dividend) and final 64-bit divide
    localparam logic [STEP_W-1:0] STEPS_Z   = 7'd48;
    localparam logic [STEP_W-1:0] STEPS_VAR = 7'd64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // one classified item as queued for the back end
    typedef struct packed {
        logic              has_value;
        logic              row_end;
        logic              sd_zero;
        logic              diff_neg;
        logic [DATA_W-1:0] diff_mag;
        logic [DATA_W-1:0] mean_mag;
        logic [DATA_W-1:0] sd;
    } t_op;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [SUM_W-1:0]  num;
        logic [DATA_W-1:0] den;
    } t_div_req;

endpackage

`default_nettype wire

// ===== sv/csrv_front.sv =====
`default_nettype none

module csrv_front (
    input  wire logic           i_valid,
    input  wire logic [95:0]    i_data,
    input  wire logic           i_has_value,
    input  wire logic           i_row_end,
    input  wire logic           i_q_full,
    output logic                o_ready,
    output logic                o_push,
    output csrv_pkg::t_op       o_op
);
    import csrv_pkg::*;

    logic [DATA_W-1:0] w_x;
    logic [DATA_W-1:0] w_mean;
    logic [DATA_W-1:0] w_sd;
    logic [DATA_W:0]   w_diff;
    logic [DATA_W:0]   w_diff_abs;
    logic [DATA_W:0]   w_mean_ext;
    logic [DATA_W:0]   w_mean_abs;

    assign w_x    = i_data[31:0];
    assign w_mean = i_data[63:32];
    assign w_sd   = i_data[95:64];

    // x - mean is exact in 33 bits, its magnitude fits 32
    assign w_diff     = {w_x[DATA_W-1], w_x} - {w_mean[DATA_W-1], w_mean};
    assign w_diff_abs = w_diff[DATA_W] ? ((DATA_W+1)'(0) - w_diff) : w_diff;
    assign w_mean_ext = {w_mean[DATA_W-1], w_mean};
    assign w_mean_abs = w_mean[DATA_W-1] ? ((DATA_W+1)'(0) - w_mean_ext) : w_mean_ext;

    // items with neither value nor row end are dropped here
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full && (i_has_value || i_row_end);

    always_comb begin
        o_op.has_value = i_has_value;
        o_op.row_end   = i_row_end;
        o_op.sd_zero   = (w_sd == '0);
        o_op.diff_neg  = w_diff[DATA_W];
        o_op.diff_mag  = w_diff_abs[DATA_W-1:0];
        o_op.mean_mag  = w_mean_abs[DATA_W-1:0];
        o_op.sd        = w_sd;
    end

endmodule

`default_nettype wire

// ===== sv/csrv_queue.sv =====
`default_nettype none

module csrv_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire csrv_pkg::t_op  i_op,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output csrv_pkg::t_op       o_op
);
    import csrv_pkg::*;

    t_op               r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

endmodule

`default_nettype wire

// ===== sv/csrv_div.sv =====
`default_nettype none

module csrv_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire csrv_pkg::t_div_req i_req,
    output logic                   o_done,
    output logic [63:0]            o_quo
);
    import csrv_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [SUM_W-1:0]    r_num;
    logic [DATA_W-1:0]   r_rem;
    logic [DATA_W-1:0]   r_den;
    logic [SUM_W-1:0]    r_quo;

    logic [DATA_W:0]     w_rem_sh;
    logic [DATA_W:0]     w_rem_sub;
    logic                w_ge;

    // restoring division, one quotient bit per cycle, dividend left aligned
    assign w_rem_sh  = {r_rem, r_num[SUM_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[SUM_W-2:0], 1'b0};
            r_rem <= w_ge ? w_rem_sub[DATA_W-1:0] : w_rem_sh[DATA_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

// ===== sv/csrv_back.sv =====
`default_nettype none

module csrv_back #(
    parameter int unsigned MAX_ROW_LENGTH = 65536
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire csrv_pkg::t_cfg_idx i_cfg_addr,
    input  wire logic [31:0]        i_cfg_wdata,
    input  wire logic               i_q_valid,
    input  wire csrv_pkg::t_op      i_q_op,
    output logic                    o_q_pop,
    output csrv_pkg::t_div_req      o_div_req,
    input  wire logic               i_div_done,
    input  wire logic [63:0]        i_div_quo,
    output logic                    o_m_valid,
    input  wire logic               i_m_ready,
    output logic [47:0]             o_m_var,
    output csrv_pkg::t_status       o_m_status
);
    import csrv_pkg::*;

    localparam int unsigned CNT_LIMIT = 2**COUNT_W - 1;
    localparam int unsigned LEN_CAP   =
        (MAX_ROW_LENGTH > CNT_LIMIT) ? CNT_LIMIT : MAX_ROW_LENGTH;
    localparam logic [COUNT_W-1:0] LEN_MAX = COUNT_W'(LEN_CAP);
    localparam logic [COUNT_W-1:0] LEN_MIN = COUNT_W'(2);
    localparam logic [DATA_W-1:0]  MAG_MAX = 32'h8000_0000;
    localparam logic signed [49:0] Z_MIN   = -50'sd2147483648;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_EDIV = 11'b000_0000_0010,
        S_ESQ  = 11'b000_0000_0100,
        S_EACC = 11'b000_0000_1000,
        S_END  = 11'b000_0001_0000,
        S_MDIV = 11'b000_0010_0000,
        S_MSQ  = 11'b000_0100_0000,
        S_MMUL = 11'b000_1000_0000,
        S_MADD = 11'b001_0000_0000,
        S_VDIV = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } t_state;

    // control state
    t_state              r_state, n_state;
    logic [DATA_W-1:0]   r_clip_max;
    logic [COUNT_W-1:0]  r_row_length;
    logic [SUM_W-1:0]    r_ssum, n_ssum;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_ovf, n_ovf;
    logic                r_out_valid, n_out_valid;

    // payload
    t_op                 r_op, n_op;
    logic [DATA_W-1:0]   r_mag, n_mag;
    logic [SUM_W-1:0]    r_prod, n_prod;
    logic [COUNT_W-1:0]  r_nzero, n_nzero;
    logic [VAR_W-1:0]    r_res_var, n_res_var;
    t_status             r_res_status, n_res_status;
    logic [VAR_W-1:0]    r_out_var, n_out_var;
    t_status             r_out_status, n_out_status;

    logic [COUNT_W-1:0]  w_len;
    logic                w_too_many;
    logic [49:0]         w_zq;
    logic signed [49:0]  w_z;
    logic signed [49:0]  w_cm;
    logic                w_clip;
    logic                w_zlow;
    logic [DATA_W:0]     w_cm_ext;
    logic [DATA_W:0]     w_cm_abs;
    logic [DATA_W-1:0]   w_emag;
    logic                w_mbig;
    logic [DATA_W-1:0]   w_mmag;
    logic [SUM_W-1:0]    w_sq;
    logic [SUM_W-1:0]    w_tn;
    logic [SUM_W-1:0]    w_add_b;
    logic [SUM_W:0]      w_sum65;
    logic                w_sat;
    logic [SUM_W-1:0]    w_sumv;
    logic                w_vsat;
    logic                w_load;

    // effective row length, clamped to the supported range
    always_comb begin
        w_len = r_row_length;
        if (w_len < LEN_MIN) begin
            w_len = LEN_MIN;
        end else if (w_len > LEN_MAX) begin
            w_len = LEN_MAX;
        end
    end
    assign w_too_many = (r_count > w_len);

    // standardized entry: sign, upper clip, lower saturation
    assign w_zq     = {2'b00, i_div_quo[47:0]};
    assign w_z      = r_op.diff_neg ? $signed(50'd0 - w_zq) : $signed(w_zq);
    assign w_cm     = $signed({{18{r_clip_max[DATA_W-1]}}, r_clip_max});
    assign w_clip   = (w_z > w_cm);
    assign w_zlow   = (w_z < Z_MIN);
    assign w_cm_ext = {r_clip_max[DATA_W-1], r_clip_max};
    assign w_cm_abs = r_clip_max[DATA_W-1] ? ((DATA_W+1)'(0) - w_cm_ext) : w_cm_ext;
    assign w_emag   = w_clip ? w_cm_abs[DATA_W-1:0] :
                      (w_zlow ? MAG_MAX : i_div_quo[DATA_W-1:0]);

    // mean/sd term, saturated at 2^31
    assign w_mbig = (i_div_quo[47:0] > {16'b0, MAG_MAX});
    assign w_mmag = w_mbig ? MAG_MAX : i_div_quo[DATA_W-1:0];

    // multipliers: square, then zero term times zero count
    assign w_sq = SUM_W'(r_mag) * SUM_W'(r_mag);
    assign w_tn = SUM_W'(r_prod[62:16]) * SUM_W'(r_nzero);

    // saturating accumulate
    assign w_add_b = (r_state == S_MADD) ? r_prod : {16'b0, r_prod[SUM_W-1:16]};
    assign w_sum65 = {1'b0, r_ssum} + {1'b0, w_add_b};
    assign w_sat   = w_sum65[SUM_W];
    assign w_sumv  = w_sat ? '1 : w_sum65[SUM_W-1:0];

    assign w_vsat = (i_div_quo[SUM_W-1:VAR_W] != '0);
    assign w_load = (r_state == S_OUT) && (!r_out_valid || i_m_ready);

    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_m_valid  = r_out_valid;
    assign o_m_var    = r_out_var;
    assign o_m_status = r_out_status;

    // divider requests
    always_comb begin
        o_div_req.start = 1'b0;
        o_div_req.steps = STEPS_Z;
        o_div_req.num   = '0;
        o_div_req.den   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && i_q_op.has_value && !i_q_op.sd_zero) begin
                    o_div_req.start = 1'b1;
                    o_div_req.num   = {i_q_op.diff_mag, 32'b0};
                    o_div_req.den   = i_q_op.sd;
                end
            end
            S_END: begin
                if (!r_op.sd_zero && !w_too_many) begin
                    o_div_req.start = 1'b1;
                    o_div_req.num   = {r_op.mean_mag, 32'b0};
                    o_div_req.den   = r_op.sd;
                end
            end
            S_MADD: begin
                o_div_req.start = 1'b1;
                o_div_req.steps = STEPS_VAR;
                o_div_req.num   = w_sumv;
                o_div_req.den   = {15'b0, w_len - 1'b1};
            end
            default: begin
                o_div_req.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_ssum       = r_ssum;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_out_valid  = r_out_valid;
        n_op         = r_op;
        n_mag        = r_mag;
        n_prod       = r_prod;
        n_nzero      = r_nzero;
        n_res_var    = r_res_var;
        n_res_status = r_res_status;
        n_out_var    = r_out_var;
        n_out_status = r_out_status;

        if (r_out_valid && i_m_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_op = i_q_op;
                    if (i_q_op.has_value && r_count != COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                    if (i_q_op.has_value && !i_q_op.sd_zero) begin
                        n_state = S_EDIV;
                    end else begin
                        n_state = S_END;
                    end
                end
            end
            S_EDIV: begin
                if (i_div_done) begin
                    n_mag = w_emag;
                    if (!w_clip && w_zlow) begin
                        n_ovf = 1'b1;
                    end
                    n_state = S_ESQ;
                end
            end
            S_ESQ: begin
                n_prod  = w_sq;
                n_state = S_EACC;
            end
            S_EACC: begin
                n_ssum = w_sumv;
                if (w_sat) begin
                    n_ovf = 1'b1;
                end
                n_state = r_op.row_end ? S_END : S_IDLE;
            end
            S_END: begin
                // a value item with zero sd and no row end closes nothing
                if (!r_op.row_end) begin
                    n_state = S_IDLE;
                end else if (r_op.sd_zero) begin
                    n_res_var    = '0;
                    n_res_status = ST_SD_ZERO;
                    n_state      = S_OUT;
                end else if (w_too_many) begin
                    n_res_var    = '0;
                    n_res_status = ST_SAT;
                    n_state      = S_OUT;
                end else begin
                    n_nzero = w_len - r_count;
                    n_state = S_MDIV;
                end
            end
            S_MDIV: begin
                if (i_div_done) begin
                    n_mag = w_mmag;
                    if (w_mbig) begin
                        n_ovf = 1'b1;
                    end
                    n_state = S_MSQ;
                end
            end
            S_MSQ: begin
                n_prod  = w_sq;
                n_state = S_MMUL;
            end
            S_MMUL: begin
                n_prod  = w_tn;
                n_state = S_MADD;
            end
            S_MADD: begin
                n_ssum = w_sumv;
                if (w_sat) begin
                    n_ovf = 1'b1;
                end
                n_state = S_VDIV;
            end
            S_VDIV: begin
                if (i_div_done) begin
                    n_res_var    = w_vsat ? '1 : i_div_quo[VAR_W-1:0];
                    n_res_status = (r_ovf || w_vsat) ? ST_SAT : ST_OK;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (w_load) begin
                    n_out_valid  = 1'b1;
                    n_out_var    = r_res_var;
                    n_out_status = r_res_status;
                    n_ssum       = '0;
                    n_count      = '0;
                    n_ovf        = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ssum       <= '0;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_clip_max   <= 32'd655360;
            r_row_length <= COUNT_W'(65536);
        end else begin
            r_state     <= n_state;
            r_ssum      <= n_ssum;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_CLIP_MAX:   r_clip_max   <= i_cfg_wdata;
                    CFG_ROW_LENGTH: r_row_length <= i_cfg_wdata[COUNT_W-1:0];
                    default:        r_clip_max   <= r_clip_max;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_mag        <= n_mag;
        r_prod       <= n_prod;
        r_nzero      <= n_nzero;
        r_res_var    <= n_res_var;
        r_res_status <= n_res_status;
        r_out_var    <= n_out_var;
        r_out_status <= n_out_status;
    end

endmodule

`default_nettype wire

// ===== sv/clipped_standardized_row_variance_top.sv =====
// Clipped standardized row variance. Each input beat carries one nonzero entry of a
// sparse row (tuser = 1) with the row mean and sd, or only closes the row (tuser = 0,
// tlast = 1); tlast marks the row's last beat, which yields one output beat with the
// variance (Q32.16, saturating) and a status (0 ok, 1 sd zero, 2 saturated or too many
// entries). A four-deep queue separates the input side from the arithmetic, so input
// beats are taken while earlier entries are still being processed. The pace is set
// by the single shared restoring divider (one quotient bit per cycle): an entry with
// nonzero sd needs a 48-bit divide, squaring and accumulate; an entry with zero sd
// or a beat without value needs no divide; a row close adds a 48-bit mean/sd divide,
// squaring, zero-term multiply, 64-bit divide by length minus one. Beats with neither
// value nor last are dropped at the input. Configuration writes (index 0 clip_max,
// index 1 row_length) take effect at once and are meant for idle time between rows.
`default_nettype none

module clipped_standardized_row_variance_top #(
    parameter int unsigned MAX_ROW_LENGTH = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,   // entry_value[31:0], row_mean[63:32], row_sd[95:64]
    input  wire logic        s_axis_tuser,   // has_value
    input  wire logic        s_axis_tlast,   // row_end
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // variance[47:0]
    output logic [1:0]       m_axis_tuser    // status[1:0]
);
    import csrv_pkg::*;

    logic     w_q_full;
    logic     w_push;
    t_op      w_push_op;
    logic     w_q_valid;
    t_op      w_q_op;
    logic     w_q_pop;
    t_div_req w_div_req;
    logic     w_div_done;
    logic [SUM_W-1:0] w_div_quo;
    t_status  w_status;

    csrv_front u_front (
        .i_valid     (s_axis_tvalid),
        .i_data      (s_axis_tdata),
        .i_has_value (s_axis_tuser),
        .i_row_end   (s_axis_tlast),
        .i_q_full    (w_q_full),
        .o_ready     (s_axis_tready),
        .o_push      (w_push),
        .o_op        (w_push_op)
    );

    csrv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_op    (w_q_op)
    );

    csrv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    csrv_back #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_op      (w_q_op),
        .o_q_pop     (w_q_pop),
        .o_div_req   (w_div_req),
        .i_div_done  (w_div_done),
        .i_div_quo   (w_div_quo),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_var     (m_axis_tdata),
        .o_m_status  (w_status)
    );

    assign m_axis_tuser = w_status;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import csrv_pkg::*;

    localparam int unsigned MAX_LEN        = 65536;
    localparam longint      MAG_FLOOR      = -64'sd2147483648;
    localparam logic [63:0] MAG_CEIL       = 64'h0000_0000_8000_0000;
    localparam logic [63:0] VAR_MAX        = 64'h0000_FFFF_FFFF_FFFF;
    localparam int          SETTLE_CYCLES  = 300;
    localparam int          HOLD_CYCLES    = 3000;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          PHASE_BEATS    = 55;

    // one input beat as the sender sees it
    typedef struct {
        bit          has_value;
        logic [31:0] entry_value;
        logic [31:0] row_mean;
        logic [31:0] row_sd;
        bit          row_end;
    } row_beat_t;

    typedef struct {
        logic [47:0] variance;
        t_status     status;
    } variance_result_t;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    // row variance predictor and result checker
    class row_variance_scoreboard;
        logic signed [31:0] clip_max;
        logic [16:0]        row_length;
        logic [63:0]        square_sum;
        logic [16:0]        clipped_count;
        logic [16:0]        entry_count;
        bit                 overflow_seen;
        variance_result_t   variance_queue[$];
        int                 errors;
        int                 results_seen;

        function new();
            clip_max   = 32'sd655360;
            row_length = 17'd65536;
            errors     = 0;
            results_seen = 0;
            clear_row();
        endfunction

        function void clear_row();
            square_sum    = '0;
            clipped_count = '0;
            entry_count   = '0;
            overflow_seen = 1'b0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] value);
            if (idx == CFG_CLIP_MAX)
                clip_max = value;
            else if (idx == CFG_ROW_LENGTH)
                row_length = value[16:0];
        endfunction

        function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (s[64]) begin
                overflow_seen = 1'b1;
                return '1;
            end
            return s[63:0];
        endfunction

        function int pending();
            return variance_queue.size();
        endfunction

        // fold one accepted beat into the row state; row end yields the expected result
        function void take_beat(row_beat_t b);
            longint           diff, z, m;
            logic [63:0]      mag, mm, q, term, total, nzero, len, quot;
            logic [127:0]     prod;
            variance_result_t r;
            if (b.has_value) begin
                if (entry_count != COUNT_MAX)
                    entry_count++;
                if (b.row_sd != 0) begin
                    diff = longint'($signed(b.entry_value)) - longint'($signed(b.row_mean));
                    z = (diff * 65536) / longint'({32'd0, b.row_sd});
                    if (z > longint'(clip_max)) begin
                        z = clip_max;
                        if (clipped_count != COUNT_MAX)
                            clipped_count++;
                    end
                    if (z < MAG_FLOOR) begin
                        z = MAG_FLOOR;
                        overflow_seen = 1'b1;
                    end
                    mag = (z < 0) ? 64'(-z) : 64'(z);
                    square_sum = sat_sum(square_sum, (mag * mag) >> 16);
                end
            end
            if (!b.row_end)
                return;

            len = 64'(row_length);
            if (len < 2)
                len = 2;
            if (len > MAX_LEN)
                len = MAX_LEN;
            r.variance = '0;
            r.status   = ST_OK;
            if (b.row_sd == 0) begin
                r.status = ST_SD_ZERO;
            end else if (64'(entry_count) > len) begin
                r.status = ST_SAT;
            end else begin
                // implicit zero entries each add (mean/sd)^2
                nzero = len - 64'(entry_count);
                m = longint'($signed(b.row_mean));
                mm = (m < 0) ? 64'(-m) : 64'(m);
                q = (mm << 16) / {32'd0, b.row_sd};
                if (q > MAG_CEIL) begin
                    q = MAG_CEIL;
                    overflow_seen = 1'b1;
                end
                term = (q * q) >> 16;
                prod = 128'(term) * 128'(nzero);
                if (prod[127:64] != 0) begin
                    overflow_seen = 1'b1;
                    total = '1;
                end else begin
                    total = sat_sum(square_sum, prod[63:0]);
                end
                quot = total / (len - 1);
                if (quot > VAR_MAX) begin
                    quot = VAR_MAX;
                    overflow_seen = 1'b1;
                end
                r.variance = quot[47:0];
                if (overflow_seen)
                    r.status = ST_SAT;
            end
            variance_queue.push_back(r);
            clear_row();
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("ERROR result %0d: %s", results_seen, msg);
            errors++;
        endtask

        task check_result(logic [47:0] variance, t_status status);
            variance_result_t exp_r;
            results_seen++;
            if (variance_queue.size() == 0) begin
                report($sformatf("unexpected beat variance=%h status=%0d", variance, status));
                return;
            end
            exp_r = variance_queue.pop_front();
            if (variance !== exp_r.variance)
                report($sformatf("variance %h, predicted %h", variance, exp_r.variance));
            if (status !== exp_r.status)
                report($sformatf("status %0d, predicted %0d", status, exp_r.status));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_addr;
    logic [31:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // entry_value[31:0], row_mean[63:32], row_sd[95:64]
    logic        s_axis_tuser;   // has_value
    logic        s_axis_tlast;   // row_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // variance[47:0]
    logic [1:0]  m_axis_tuser;   // status[1:0]

    row_variance_scoreboard sb = new();

    bit hold_req;
    bit no_gaps;
    int burst_left;
    int beats_sent;
    int cur_len;
    int idle_cycles;

    clipped_standardized_row_variance_top #(
        .MAX_ROW_LENGTH(MAX_LEN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // register write, one cycle of enable, then enable dropped again before returning
    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        sb.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // offer one beat and hold it until taken
    task automatic send_beat(input row_beat_t b);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.row_sd, b.row_mean, b.entry_value};
        s_axis_tuser  <= b.has_value;
        s_axis_tlast  <= b.row_end;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_beat(b);
        if (b.has_value || b.row_end)
            beats_sent++;
        @(negedge i_clk);
    endtask

    // sender bursts: random gap once a burst runs out
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 24);
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        while (sb.pending() > 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_sd();
        case ($urandom_range(0, 15))
            0: return 32'd0;
            1: return $urandom;
            2: return $urandom_range(1, 16);
            3: return {1'b1, 31'($urandom)};
            default: return $urandom_range(1 << 12, 1 << 20);
        endcase
    endfunction

    function automatic logic [31:0] pick_mean();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'd0;
            2: return 32'h8000_0000;
            default: return $urandom_range(0, 1 << 22) - (1 << 21);
        endcase
    endfunction

    function automatic logic [31:0] pick_entry(logic [31:0] mean);
        int span;
        span = 1 << $urandom_range(4, 24);
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'd0;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return mean + ($urandom_range(0, 2 * span) - span);
        endcase
    endfunction

    // one row: mostly consistent mean/sd, with stray idle beats and sd changes mixed in
    task automatic random_row();
        int          n;
        logic [31:0] mean, sd;
        bit          close_beat;
        n = (cur_len <= 40) ? $urandom_range(0, cur_len + 2) : $urandom_range(0, 10);
        mean = pick_mean();
        sd = pick_sd();
        close_beat = (n == 0) || ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                pace();
                send_beat('{1'b0, $urandom, $urandom, $urandom, 1'b0});
            end
            if ($urandom_range(0, 11) == 0)
                sd = pick_sd();
            pace();
            send_beat('{1'b1, pick_entry(mean), mean, sd, (k == n - 1) && !close_beat});
        end
        if (close_beat) begin
            pace();
            send_beat('{1'b0, $urandom, mean, sd, 1'b1});
        end
    endtask

    // stimulus
    initial begin
        logic [31:0] clip_set[8];
        logic [16:0] len_set[8];
        int          phase_end;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_CLIP_MAX;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        hold_req      = 1'b0;
        no_gaps       = 1'b0;
        burst_left    = 0;
        beats_sent    = 0;
        cur_len       = MAX_LEN;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows at reset settings
        pace(); send_beat('{1'b0, 32'd0, 32'h0001_0000, 32'h0001_0000, 1'b1});       // empty row
        pace(); send_beat('{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}); // ignored
        pace(); send_beat('{1'b1, 32'd0, 32'h0001_0000, 32'h0001_0000, 1'b0});       // zero value
        pace(); send_beat('{1'b1, 32'h0003_0000, 32'h0001_0000, 32'd0, 1'b0});       // sd zero entry
        pace(); send_beat('{1'b1, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000, 1'b1}); // clipped
        pace(); send_beat('{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1'b1});       // z saturates
        pace(); send_beat('{1'b1, 32'd5, 32'd3, 32'd0, 1'b1});                       // sd zero at end
        pace(); send_beat('{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0});
        pace(); send_beat('{1'b1, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0});
        pace(); send_beat('{1'b0, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1});
        pace(); send_beat('{1'b1, 32'h0001_8000, 32'h0000_8000, 32'h0002_0000, 1'b0});
        pace(); send_beat('{1'b1, 32'h0000_0000, 32'h0000_8000, 32'h0002_0000, 1'b0});
        pace(); send_beat('{1'b1, 32'hFFFF_0000, 32'h0000_8000, 32'h0002_0000, 1'b1});
        s_axis_tvalid <= 1'b0;

        // settings per phase: clip extremes, lengths below, at and above the legal range
        clip_set = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, $urandom,
                     32'd655360, $urandom_range(0, 1 << 21) - (1 << 20), $urandom, $urandom};
        len_set  = '{17'd2, 17'd5, 17'd0, 17'h1FFFF, 17'd16, 17'd1,
                     17'($urandom_range(2, 40)), 17'd65536};
        for (int p = 0; p < 8; p++) begin
            @(negedge i_clk);
            wait_idle();
            write_reg(CFG_CLIP_MAX, clip_set[p]);
            write_reg(CFG_ROW_LENGTH, {15'd0, len_set[p]});
            cur_len = (len_set[p] < 2) ? 2 : (len_set[p] > MAX_LEN) ? MAX_LEN : len_set[p];
            no_gaps = (p == 2) || (p == 6);
            if (p == 4)
                hold_req = 1'b1;
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end)
                random_row();
            s_axis_tvalid <= 1'b0;
        end

        @(negedge i_clk);
        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // receiver: changing stall patterns, plus one long hold-off on request
    initial begin
        rx_mode_t mode;
        int       mode_left;
        int       tick;
        mode      = RX_OPEN;
        mode_left = 0;
        tick      = 0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 400);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:     m_axis_tready <= 1'b1;
                    RX_RANDOM:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: m_axis_tready <= (tick % 5) < 2;
                    default:     m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // watchdog on cycles with no beat on either side
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== sim.f =====
sv/csrv_pkg.sv
sv/csrv_front.sv
sv/csrv_queue.sv
sv/csrv_div.sv
sv/csrv_back.sv
sv/clipped_standardized_row_variance_top.sv
test/tb.sv
